// File: sv/fof_pkg.sv
// Shared types and constants for the frequency-of-frequency table.
`default_nettype none
package fof_pkg;

    localparam int KEY_BITS_DEF   = 10;
    localparam int COUNT_BITS_DEF = 10;
    localparam int VALUE_BITS     = 10;
    localparam int OP_BITS        = 2;
    localparam int S_TDATA_BITS   = 16;
    localparam int M_TDATA_BITS   = 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_FROM,
        ST_TO,
        ST_QUERY
    } state_t;

    // control side of one queued command
    typedef struct packed {
        logic valid;
        op_t  op;
        logic in_range;
    } cmd_ctl_t;

endpackage
`default_nettype wire

// File: sv/frequency_of_frequency_table.sv
// Top level of the frequency-of-frequency table.
//
//  channel  dir  beat fields (tdata, low bit up)      notes
//  s_       in   op[1:0], value[11:2], zero pad      op 3 is taken and dropped
//  m_       out  found[0], zero pad                   one beat per query
//
// Insert/remove: count read, tally read, then two tally writes on the one write port;
// a first insert skips the decrement write; when the count stays as it is, only
// the count read. Query: tally read, result load. Commands run one at a time.
// After reset a sweep over 2**max(KEY_BITS, COUNT_BITS) addresses zeroes both
// memories, with s_tready low.
// A two-entry command queue takes beats while the result register waits on m_tready.
`default_nettype none
module frequency_of_frequency_table #(
    parameter int KEY_BITS   = fof_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = fof_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [fof_pkg::S_TDATA_BITS-1:0]  s_tdata,  // op[1:0], value[11:2]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [fof_pkg::M_TDATA_BITS-1:0]  m_tdata   // found[0]
);

    fof_pkg::cmd_ctl_t     cmd;
    logic [KEY_BITS-1:0]   cmd_key;
    logic [COUNT_BITS-1:0] cmd_cnt;
    logic                  cmd_pop;
    logic                  clear_busy;

    logic                  key_we;
    logic [KEY_BITS-1:0]   key_waddr;
    logic [COUNT_BITS:0]   key_wdata;
    logic [KEY_BITS-1:0]   key_raddr;
    logic [COUNT_BITS:0]   key_rdata;
    logic                  tally_we;
    logic [COUNT_BITS-1:0] tally_waddr;
    logic [KEY_BITS:0]     tally_wdata;
    logic [COUNT_BITS-1:0] tally_raddr;
    logic [KEY_BITS:0]     tally_rdata;

    fof_front #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .clear_busy (clear_busy),
        .cmd        (cmd),
        .cmd_key    (cmd_key),
        .cmd_cnt    (cmd_cnt),
        .cmd_pop    (cmd_pop)
    );

    // seen flag on top of the per-key count
    fof_ram #(
        .WIDTH (COUNT_BITS + 1),
        .DEPTH (1 << KEY_BITS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    fof_ram #(
        .WIDTH (KEY_BITS + 1),
        .DEPTH (1 << COUNT_BITS)
    ) u_tally_ram (
        .aclk  (aclk),
        .we    (tally_we),
        .waddr (tally_waddr),
        .wdata (tally_wdata),
        .raddr (tally_raddr),
        .rdata (tally_rdata)
    );

    fof_back #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cmd_key     (cmd_key),
        .cmd_cnt     (cmd_cnt),
        .cmd_pop     (cmd_pop),
        .clear_busy  (clear_busy),
        .key_we      (key_we),
        .key_waddr   (key_waddr),
        .key_wdata   (key_wdata),
        .key_raddr   (key_raddr),
        .key_rdata   (key_rdata),
        .tally_we    (tally_we),
        .tally_waddr (tally_waddr),
        .tally_wdata (tally_wdata),
        .tally_raddr (tally_raddr),
        .tally_rdata (tally_rdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

// File: sv/fof_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/fof_front.sv
// Input side: accepts beats, decodes the operation and queues commands.
`default_nettype none
module fof_front #(
    parameter int KEY_BITS   = fof_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = fof_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [fof_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  wire logic                              clear_busy,
    output fof_pkg::cmd_ctl_t                      cmd,
    output logic      [KEY_BITS-1:0]               cmd_key,
    output logic      [COUNT_BITS-1:0]             cmd_cnt,
    input  wire logic                              cmd_pop
);

    localparam int EXT_A    = (fof_pkg::VALUE_BITS > KEY_BITS) ? fof_pkg::VALUE_BITS : KEY_BITS;
    localparam int EXT_BITS = (EXT_A > COUNT_BITS) ? EXT_A : COUNT_BITS;
    localparam int QDEPTH   = 2;
    localparam int PTR_BITS = 1;
    localparam int FILL_BITS = 2;

    logic [fof_pkg::OP_BITS-1:0]    op_raw;
    logic [fof_pkg::VALUE_BITS-1:0] value;
    logic [EXT_BITS-1:0]            value_ext;
    fof_pkg::op_t                   op;
    logic                           op_ok;
    logic                           push;

    fof_pkg::op_t          q_op_reg    [QDEPTH];
    logic                  q_range_reg [QDEPTH];
    logic [KEY_BITS-1:0]   q_key_reg   [QDEPTH];
    logic [COUNT_BITS-1:0] q_cnt_reg   [QDEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;

    assign op_raw    = s_tdata[fof_pkg::OP_BITS-1:0];
    assign value     = s_tdata[fof_pkg::OP_BITS +: fof_pkg::VALUE_BITS];
    assign value_ext = EXT_BITS'(value);
    assign op        = fof_pkg::op_t'(op_raw);

    always_comb begin
        case (op)
            fof_pkg::OP_INSERT: op_ok = 1'b1;
            fof_pkg::OP_REMOVE: op_ok = 1'b1;
            fof_pkg::OP_QUERY:  op_ok = 1'b1;
            default:            op_ok = 1'b0;
        endcase
    end

    assign s_tready = (fill_reg != FILL_BITS'(QDEPTH)) && !clear_busy;
    assign push     = s_tvalid && s_tready && op_ok;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(cmd_pop);
        fill_next   = fill_reg + FILL_BITS'(push) - FILL_BITS'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_op_reg[wr_ptr_reg]    <= op;
            q_range_reg[wr_ptr_reg] <= (value_ext >> COUNT_BITS) == '0;
            q_key_reg[wr_ptr_reg]   <= value_ext[KEY_BITS-1:0];
            q_cnt_reg[wr_ptr_reg]   <= value_ext[COUNT_BITS-1:0];
        end
    end

    always_comb begin
        cmd.valid    = fill_reg != '0;
        cmd.op       = q_op_reg[rd_ptr_reg];
        cmd.in_range = q_range_reg[rd_ptr_reg];
        cmd_key      = q_key_reg[rd_ptr_reg];
        cmd_cnt      = q_cnt_reg[rd_ptr_reg];
    end

endmodule
`default_nettype wire

// File: sv/fof_back.sv
// Execution side: clearing sweep, count and tally updates, query results.
`default_nettype none
module fof_back #(
    parameter int KEY_BITS   = fof_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = fof_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  fof_pkg::cmd_ctl_t                      cmd,
    input  wire logic [KEY_BITS-1:0]               cmd_key,
    input  wire logic [COUNT_BITS-1:0]             cmd_cnt,
    output logic                                   cmd_pop,
    output logic                                   clear_busy,
    output logic                                   key_we,
    output logic      [KEY_BITS-1:0]               key_waddr,
    output logic      [COUNT_BITS:0]               key_wdata,
    output logic      [KEY_BITS-1:0]               key_raddr,
    input  wire logic [COUNT_BITS:0]               key_rdata,
    output logic                                   tally_we,
    output logic      [COUNT_BITS-1:0]             tally_waddr,
    output logic      [KEY_BITS:0]                 tally_wdata,
    output logic      [COUNT_BITS-1:0]             tally_raddr,
    input  wire logic [KEY_BITS:0]                 tally_rdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [fof_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    localparam int CLR_BITS = (KEY_BITS > COUNT_BITS) ? KEY_BITS : COUNT_BITS;
    localparam int TB       = KEY_BITS + 1;

    fof_pkg::state_t       state_reg, state_next;
    logic [CLR_BITS-1:0]   clr_reg, clr_next;
    fof_pkg::op_t          op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  range_reg, range_next;
    logic [COUNT_BITS-1:0] from_reg, from_next;
    logic [COUNT_BITS-1:0] to_reg, to_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg, found_next;

    logic                  seen;
    logic [COUNT_BITS-1:0] cur;

    assign seen = key_rdata[COUNT_BITS];
    assign cur  = key_rdata[COUNT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fof_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        cnt_reg   <= cnt_next;
        range_reg <= range_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        found_reg <= found_next;
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        range_next     = range_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        out_valid_next = out_valid_reg && !m_tready;
        found_next     = found_reg;
        cmd_pop        = 1'b0;
        key_we         = 1'b0;
        key_waddr      = key_reg;
        key_wdata      = '0;
        key_raddr      = key_reg;
        tally_we       = 1'b0;
        tally_waddr    = from_reg;
        tally_wdata    = '0;
        tally_raddr    = to_reg;

        case (state_reg)
            fof_pkg::ST_CLEAR: begin
                key_we      = 1'b1;
                key_waddr   = clr_reg[KEY_BITS-1:0];
                tally_we    = 1'b1;
                tally_waddr = clr_reg[COUNT_BITS-1:0];
                clr_next    = clr_reg + CLR_BITS'(1);
                if (clr_reg == '1) begin
                    state_next = fof_pkg::ST_IDLE;
                end
            end
            fof_pkg::ST_IDLE: begin
                key_raddr   = cmd_key;
                tally_raddr = cmd_cnt;
                if (cmd.valid) begin
                    cmd_pop    = 1'b1;
                    op_next    = cmd.op;
                    key_next   = cmd_key;
                    cnt_next   = cmd_cnt;
                    range_next = cmd.in_range;
                    if (cmd.op == fof_pkg::OP_QUERY) begin
                        state_next = fof_pkg::ST_QUERY;
                    end else begin
                        state_next = fof_pkg::ST_KEY;
                    end
                end
            end
            fof_pkg::ST_KEY: begin
                state_next = fof_pkg::ST_IDLE;
                if (op_reg == fof_pkg::OP_INSERT) begin
                    if (!seen) begin
                        // first insert: only the tally of one rises
                        key_we      = 1'b1;
                        key_wdata   = {1'b1, COUNT_BITS'(1)};
                        to_next     = COUNT_BITS'(1);
                        tally_raddr = COUNT_BITS'(1);
                        state_next  = fof_pkg::ST_TO;
                    end else if (cur != '1) begin
                        key_we      = 1'b1;
                        key_wdata   = {1'b1, cur + COUNT_BITS'(1)};
                        from_next   = cur;
                        to_next     = cur + COUNT_BITS'(1);
                        tally_raddr = cur;
                        state_next  = fof_pkg::ST_FROM;
                    end
                end else if (seen && (cur != '0)) begin
                    key_we      = 1'b1;
                    key_wdata   = {1'b1, cur - COUNT_BITS'(1)};
                    from_next   = cur;
                    to_next     = cur - COUNT_BITS'(1);
                    tally_raddr = cur;
                    state_next  = fof_pkg::ST_FROM;
                end
            end
            fof_pkg::ST_FROM: begin
                tally_we    = 1'b1;
                tally_waddr = from_reg;
                tally_wdata = tally_rdata - TB'(1);
                tally_raddr = to_reg;
                state_next  = fof_pkg::ST_TO;
            end
            fof_pkg::ST_TO: begin
                tally_we    = 1'b1;
                tally_waddr = to_reg;
                tally_wdata = tally_rdata + TB'(1);
                state_next  = fof_pkg::ST_IDLE;
            end
            fof_pkg::ST_QUERY: begin
                tally_raddr = cnt_reg;
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    found_next     = range_reg && (tally_rdata != '0);
                    state_next     = fof_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fof_pkg::ST_IDLE;
            end
        endcase
    end

    assign clear_busy = state_reg == fof_pkg::ST_CLEAR;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = fof_pkg::M_TDATA_BITS'(found_reg);

endmodule
`default_nettype wire

// File: tb/frequency_of_frequency_table_test.sv
// Testbench for frequency_of_frequency_table: random and directed op beats, checked answers.
`default_nettype none
module frequency_of_frequency_table_test;

    localparam int          KEY_BITS     = fof_pkg::KEY_BITS_DEF;
    localparam int          COUNT_BITS   = fof_pkg::COUNT_BITS_DEF;
    localparam int          VALUE_BITS   = fof_pkg::VALUE_BITS;
    localparam int          OP_BITS      = fof_pkg::OP_BITS;
    localparam int          S_BITS       = fof_pkg::S_TDATA_BITS;
    localparam int          M_BITS       = fof_pkg::M_TDATA_BITS;
    localparam int          NKEY         = 1 << KEY_BITS;
    localparam int          NCOUNT       = 1 << COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = COUNT_BITS'(NCOUNT - 1);
    localparam logic [1:0]  OP_DROP      = 2'd3;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          WATCHDOG     = 6000;
    localparam int          PAD_BITS     = S_BITS - OP_BITS - VALUE_BITS;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [VALUE_BITS-1:0] value;
    } op_beat_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_BITS-1:0]        s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_BITS-1:0]        m_tdata;

    frequency_of_frequency_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // shadow of the block's tables
    bit [COUNT_BITS-1:0] key_cnt [NKEY];
    bit                  key_on  [NKEY];
    bit [KEY_BITS:0]     tally   [NCOUNT];

    op_beat_t   op_pend[$];
    logic       found_due[$];
    int         hot_keys[8];
    bit         calm = 1'b0;
    int         hold_asks = 0;
    int         hold_taken = 0;
    int         hold_left = 0;
    int         stall_left = 0;
    int         gap_left = 0;
    int         ops_queued = 0;
    int         ops_taken = 0;
    int         n_ins = 0, n_rem = 0, n_qry = 0, n_drop = 0;
    int         answers = 0;
    int         fails = 0;
    int         quiet_cycles = 0;
    logic       s_done = 1'b0;
    logic       m_done = 1'b0;

    task automatic apply_op(input logic [1:0] op, input logic [VALUE_BITS-1:0] v);
        logic [COUNT_BITS-1:0] c;
        c = key_cnt[v];
        case (op)
            fof_pkg::OP_INSERT: begin
                n_ins++;
                if (!key_on[v]) begin
                    key_on[v] = 1'b1;
                    key_cnt[v] = COUNT_BITS'(1);
                    tally[1] = tally[1] + 1'b1;
                end else if (c != COUNT_TOP) begin
                    key_cnt[v] = c + 1'b1;
                    tally[c] = tally[c] - 1'b1;
                    tally[c + 1'b1] = tally[c + 1'b1] + 1'b1;
                end
            end
            fof_pkg::OP_REMOVE: begin
                n_rem++;
                if (key_on[v] && c != 0) begin
                    key_cnt[v] = c - 1'b1;
                    tally[c] = tally[c] - 1'b1;
                    tally[c - 1'b1] = tally[c - 1'b1] + 1'b1;
                end
            end
            fof_pkg::OP_QUERY: begin
                n_qry++;
                found_due = {found_due, (tally[v] != 0)};
            end
            default: n_drop++;
        endcase
    endtask

    // monitor: checks answers, tracks accepted ops, watchdog
    always @(posedge aclk) begin : watch
        logic want;
        s_done <= aresetn && s_tvalid && s_tready;
        m_done <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (found_due.size() == 0) begin
                fails++;
                $error("found: expected no beat, got %0d", m_tdata[0]);
            end else begin
                want = found_due.pop_front();
                answers++;
                if (m_tdata[0] !== want) begin
                    fails++;
                    $error("found: expected %0d, got %0d", want, m_tdata[0]);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            apply_op(s_tdata[OP_BITS-1:0], s_tdata[OP_BITS+VALUE_BITS-1:OP_BITS]);
            ops_taken++;
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("frequency_of_frequency_table_test: errors");
            $finish;
        end
    end

    // driver
    always @(negedge aclk) begin : drive
        op_beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left = 0;
        end else if (!s_tvalid || s_done) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (op_pend.size() > 0) begin
                b = op_pend.pop_front();
                s_tdata <= {{PAD_BITS{1'b0}}, b.value, b.op};
                s_tvalid <= 1'b1;
                gap_left = calm ? 0 : $urandom_range(0, 14);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result-side backpressure
    always @(negedge aclk) begin : backpressure
        int n;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_taken != hold_asks) begin
            hold_taken = hold_asks;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (m_done) begin
            n = calm ? 0 : $urandom_range(0, 14);
            stall_left = n;
            m_tready <= (n == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_op(input logic [1:0] op, input int v);
        op_beat_t b;
        b.op = op;
        b.value = VALUE_BITS'(v);
        op_pend = {op_pend, b};
        ops_queued++;
    endtask

    task automatic drain();
        while (ops_taken != ops_queued || found_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic push_random(input int n);
        int r;
        int v;
        logic [1:0] op;
        for (int i = 0; i < 8; i++)
            hot_keys[i] = $urandom_range(0, NKEY - 1);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                op = OP_DROP;
            else if (r < 50)
                op = fof_pkg::OP_INSERT;
            else if (r < 72)
                op = fof_pkg::OP_REMOVE;
            else
                op = fof_pkg::OP_QUERY;
            if (op == fof_pkg::OP_QUERY)
                v = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8)
                                                : $urandom_range(0, NCOUNT - 1);
            else
                v = ($urandom_range(0, 4) != 0) ? hot_keys[$urandom_range(0, 7)]
                                                : $urandom_range(0, NKEY - 1);
            push_op(op, v);
        end
    endtask

    initial begin
        int sat_key;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // directed
        push_op(fof_pkg::OP_QUERY, 0);
        push_op(fof_pkg::OP_QUERY, 1);
        push_op(fof_pkg::OP_REMOVE, 5);
        push_op(fof_pkg::OP_INSERT, 0);
        push_op(fof_pkg::OP_INSERT, NKEY - 1);
        push_op(fof_pkg::OP_QUERY, 1);
        push_op(fof_pkg::OP_INSERT, 0);
        push_op(fof_pkg::OP_QUERY, 2);
        push_op(fof_pkg::OP_QUERY, 1);
        push_op(fof_pkg::OP_REMOVE, NKEY - 1);
        push_op(fof_pkg::OP_QUERY, 0);
        push_op(fof_pkg::OP_REMOVE, NKEY - 1);
        push_op(fof_pkg::OP_QUERY, 0);
        push_op(OP_DROP, NKEY - 1);
        push_op(OP_DROP, 0);
        push_op(fof_pkg::OP_QUERY, NCOUNT - 1);
        push_op(fof_pkg::OP_REMOVE, 0);
        push_op(fof_pkg::OP_REMOVE, 0);
        push_op(fof_pkg::OP_QUERY, 0);
        push_op(fof_pkg::OP_QUERY, 1);
        push_op(fof_pkg::OP_QUERY, 2);
        drain();

        // drive one key to the top count and past it
        calm = 1'b1;
        sat_key = $urandom_range(1, NKEY - 2);
        repeat (NCOUNT + 1) push_op(fof_pkg::OP_INSERT, sat_key);
        push_op(fof_pkg::OP_QUERY, NCOUNT - 1);
        push_op(fof_pkg::OP_REMOVE, sat_key);
        push_op(fof_pkg::OP_QUERY, NCOUNT - 1);
        push_op(fof_pkg::OP_QUERY, NCOUNT - 2);
        push_op(fof_pkg::OP_INSERT, sat_key);
        push_op(fof_pkg::OP_INSERT, sat_key);
        push_op(fof_pkg::OP_QUERY, NCOUNT - 1);
        drain();
        calm = 1'b0;

        push_random(220);
        drain();

        // long receiver hold while queries keep coming
        hold_asks++;
        for (int i = 0; i < 40; i++)
            push_op(fof_pkg::OP_QUERY, $urandom_range(0, 6));
        drain();

        push_random(220);
        drain();
        calm = 1'b1;
        push_random(200);
        drain();
        calm = 1'b0;
        push_random(220);
        drain();

        repeat (20) @(negedge aclk);
        $display("%0d ops taken: %0d inserts, %0d removes, %0d queries, %0d dropped op codes",
                 ops_taken, n_ins, n_rem, n_qry, n_drop);
        $display("%0d answers checked, including a full key count and a long output hold",
                 answers);
        if (fails == 0)
            $display("frequency_of_frequency_table_test: clean");
        else
            $display("frequency_of_frequency_table_test: errors");
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
sv/fof_pkg.sv
sv/fof_ram.sv
sv/fof_front.sv
sv/fof_back.sv
sv/frequency_of_frequency_table.sv
tb/frequency_of_frequency_table_test.sv
